@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ hdl/pebgr_pkg.sv @@
// ----------------------------------------------------------------------------
// pebgr_pkg
// Constants shared by the palette expansion block.
// ----------------------------------------------------------------------------
package pebgr_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TABLE_AW    = 8;
    localparam int COLOR_W     = 24;
    localparam int CFG_DW      = 13;

    // pixel_depth register codes; code 3 acts as 8 bpp
    localparam logic [1:0] DEPTH_1BPP = 2'd0;
    localparam logic [1:0] DEPTH_4BPP = 2'd1;
    localparam logic [1:0] DEPTH_8BPP = 2'd2;

    // configuration register indexes
    localparam logic REG_PIXEL_DEPTH = 1'b0;
    localparam logic REG_IMAGE_WIDTH = 1'b1;

    // input word kinds
    localparam logic MODE_PALETTE = 1'b0;
    localparam logic MODE_DATA    = 1'b1;

endpackage

@@ hdl/pebgr_ram.sv @@
// ----------------------------------------------------------------------------
// pebgr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pebgr_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read returns the old contents on a same-address write
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/palette_expand_to_bgr24.sv @@
// ----------------------------------------------------------------------------
// palette_expand_to_bgr24
// Expands 1, 4 or 8 bpp palette-indexed row bytes into 24-bit BGR pixels.
// ----------------------------------------------------------------------------
// Path of a pixel: expansion stage, then RAM read into the output stage.
// Throughput: one pixel per cycle unless output stalls, bound by the single
//   palette RAM read port; a byte holds the input until its last pixel issues.
// Palette writes and padding bytes give no pixel and do not hold the input.
// Reset (synchronous, active low): row position clears, depth 8 bpp, width 1;
//   palette entries read as zero until written, with no clearing pass.
`include "assert_macros.svh"

module palette_expand_to_bgr24 #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [pebgr_pkg::CFG_DW-1:0] i_cfg_data,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_mode,
    input  logic [7:0]                  i_palette_index,
    input  logic [7:0]                  i_entry_blue,
    input  logic [7:0]                  i_entry_green,
    input  logic [7:0]                  i_entry_red,
    input  logic [7:0]                  i_data_byte,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [7:0]                  o_pixel_blue,
    output logic [7:0]                  o_pixel_green,
    output logic [7:0]                  o_pixel_red,
    output logic                        o_last_of_byte,
    output logic                        o_row_end
);

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > pebgr_pkg::CFG_DW) ? WW : pebgr_pkg::CFG_DW;
    localparam int SW = WW + 4;
    localparam int PW = $clog2(MAX_WIDTH + 4);

    // configuration registers
    logic [1:0]                    r_pixel_depth;
    logic [pebgr_pkg::CFG_DW-1:0]  r_image_width;

    // row position
    logic [WW-1:0] r_pixel_column;
    logic [PW-1:0] r_row_pos;

    // expansion stage: byte being walked pixel by pixel
    logic          r_a_vld;
    logic [7:0]    r_a_byte;
    logic [1:0]    r_a_depth;
    logic [2:0]    r_a_k;
    logic [2:0]    r_a_last;
    logic [WW-1:0] r_a_col;

    // output stage: RAM read data plus flags
    logic          r_b_vld;
    logic          r_b_hit;
    logic          r_b_last;
    logic          r_b_end;

    logic [pebgr_pkg::TABLE_DEPTH-1:0] r_entry_vld;

    logic [CW-1:0]  width_ext;
    logic [WW-1:0]  w_eff;
    logic [SW-1:0]  pix_bits;
    logic [SW-1:0]  stride;
    logic [3:0]     per_byte;
    logic           row_done;
    logic [WW:0]    avail;
    logic [3:0]     n_pix;
    logic           out_free;
    logic           issue;
    logic           a_done;
    logic           in_acc;
    logic           pal_wr;
    logic           data_acc;
    logic [pebgr_pkg::TABLE_AW-1:0] rd_idx;
    logic [pebgr_pkg::COLOR_W-1:0]  rd_data;

    // ------------------------------------------------------------------
    // Row geometry
    // ------------------------------------------------------------------
    always_comb begin
        width_ext = CW'(r_image_width);
        if (width_ext == '0) begin
            w_eff = WW'(1);
        end else if (width_ext > CW'(MAX_WIDTH)) begin
            w_eff = WW'(MAX_WIDTH);
        end else begin
            w_eff = WW'(width_ext);
        end

        case (r_pixel_depth)
            pebgr_pkg::DEPTH_1BPP: begin
                pix_bits = SW'(w_eff);
                per_byte = 4'd8;
            end
            pebgr_pkg::DEPTH_4BPP: begin
                pix_bits = SW'(w_eff) << 2;
                per_byte = 4'd2;
            end
            default: begin
                pix_bits = SW'(w_eff) << 3;
                per_byte = 4'd1;
            end
        endcase

        // bytes per row, rounded up to whole 32-bit words
        stride   = ((pix_bits + SW'(31)) >> 5) << 2;
        row_done = (SW'(r_row_pos) + SW'(1)) >= stride;

        if (r_pixel_column < w_eff) begin
            avail = {1'b0, w_eff} - {1'b0, r_pixel_column};
        end else begin
            avail = '0;
        end
        if (avail >= (WW + 1)'(per_byte)) begin
            n_pix = per_byte;
        end else begin
            n_pix = avail[3:0];
        end
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    assign out_free = !r_b_vld || !i_stall;
    assign issue    = r_a_vld && out_free;
    assign a_done   = issue && (r_a_k == r_a_last);
    assign o_stall  = r_a_vld && !a_done;
    assign in_acc   = i_valid && !o_stall;
    assign pal_wr   = in_acc && (i_mode == pebgr_pkg::MODE_PALETTE);
    assign data_acc = in_acc && (i_mode == pebgr_pkg::MODE_DATA);

    // palette index of the pixel being issued
    always_comb begin
        case (r_a_depth)
            pebgr_pkg::DEPTH_1BPP: begin
                rd_idx = {7'd0, r_a_byte[3'd7 - r_a_k]};
            end
            pebgr_pkg::DEPTH_4BPP: begin
                rd_idx = (r_a_k == 3'd0) ? {4'd0, r_a_byte[7:4]} : {4'd0, r_a_byte[3:0]};
            end
            default: begin
                rd_idx = r_a_byte;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_depth <= pebgr_pkg::DEPTH_8BPP;
            r_image_width <= pebgr_pkg::CFG_DW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pebgr_pkg::REG_PIXEL_DEPTH: r_pixel_depth <= i_cfg_data[1:0];
                pebgr_pkg::REG_IMAGE_WIDTH: r_image_width <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Row position, advanced once per data word
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_column <= '0;
            r_row_pos      <= '0;
        end else if (data_acc) begin
            if (row_done) begin
                r_pixel_column <= '0;
                r_row_pos      <= '0;
            end else begin
                r_pixel_column <= r_pixel_column + WW'(n_pix);
                r_row_pos      <= r_row_pos + PW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Expansion stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (data_acc && (n_pix != 4'd0)) begin
            r_a_vld <= 1'b1;
        end else if (a_done) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (data_acc) begin
            r_a_byte  <= i_data_byte;
            r_a_depth <= r_pixel_depth;
            r_a_k     <= 3'd0;
            r_a_last  <= 3'(n_pix - 4'd1);
            r_a_col   <= r_pixel_column;
        end else if (issue) begin
            r_a_k   <= r_a_k + 3'd1;
            r_a_col <= r_a_col + WW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Palette table: RAM plus written flags
    // ------------------------------------------------------------------
    pebgr_ram #(
        .WIDTH (pebgr_pkg::COLOR_W),
        .DEPTH (pebgr_pkg::TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (pal_wr),
        .i_waddr (i_palette_index),
        .i_wdata ({i_entry_blue, i_entry_green, i_entry_red}),
        .i_re    (issue),
        .i_raddr (rd_idx),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (pal_wr) begin
            r_entry_vld[i_palette_index] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (out_free) begin
            r_b_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_b_hit  <= r_entry_vld[rd_idx];
            r_b_last <= (r_a_k == r_a_last);
            r_b_end  <= ({1'b0, r_a_col} + (WW + 1)'(1)) == {1'b0, w_eff};
        end
    end

    // unwritten entries read as zero
    assign o_valid        = r_b_vld;
    assign o_pixel_blue   = r_b_hit ? rd_data[23:16] : 8'd0;
    assign o_pixel_green  = r_b_hit ? rd_data[15:8]  : 8'd0;
    assign o_pixel_red    = r_b_hit ? rd_data[7:0]   : 8'd0;
    assign o_last_of_byte = r_b_last;
    assign o_row_end      = r_b_end;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_last_reaches_out, i_clk, i_rst_n, a_done, r_b_vld && r_b_last)
    `ASSERT_IMPLY(a_pixel_in_range, i_clk, i_rst_n, r_a_vld, r_a_k <= r_a_last)
    `ASSERT_NEXT(a_empty_word_idle, i_clk, i_rst_n, in_acc && (i_mode == pebgr_pkg::MODE_PALETTE || n_pix == 4'd0), !r_a_vld)

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for palette_expand_to_bgr24. A clocked driver feeds palette and
// row-byte words from a queue, a shadow model of the color table and the row
// position predicts every pixel, and a clocked monitor checks each pixel in
// order while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int MAX_W = 4096;
    localparam logic [1:0] DEPTH_UNDEF = 2'd3;  // treated as 8 bpp
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic       mode;
        logic [7:0] pidx;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] data;
    } t_word;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic       last;
        logic       rend;
    } t_pixel;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_index = pebgr_pkg::REG_PIXEL_DEPTH;
    logic [pebgr_pkg::CFG_DW-1:0] i_cfg_data = '0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_mode = pebgr_pkg::MODE_PALETTE;
    logic [7:0]        i_palette_index = '0;
    logic [7:0]        i_entry_blue = '0;
    logic [7:0]        i_entry_green = '0;
    logic [7:0]        i_entry_red = '0;
    logic [7:0]        i_data_byte = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [7:0]        o_pixel_blue;
    logic [7:0]        o_pixel_green;
    logic [7:0]        o_pixel_red;
    logic              o_last_of_byte;
    logic              o_row_end;

    // shadow state of the block
    logic [23:0]       color_tab [pebgr_pkg::TABLE_DEPTH];
    logic [1:0]        cfg_depth = pebgr_pkg::DEPTH_8BPP;
    logic [pebgr_pkg::CFG_DW-1:0] cfg_width = 13'd1;
    int                row_col = 0;
    int                row_pos = 0;

    t_word  pending_words [$];
    t_pixel pixel_expect [$];
    t_word  cur_word;
    t_pixel want;
    logic   word_loaded = 1'b0;
    int     gap_left = 0;
    int     stall_left = 0;
    logic   stall_now;
    logic   calm_sender = 1'b0;
    logic   calm_receiver = 1'b0;
    int     mismatch_count = 0;
    int     random_items = 0;

    palette_expand_to_bgr24 #(.MAX_WIDTH(MAX_W)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_mode          (i_mode),
        .i_palette_index (i_palette_index),
        .i_entry_blue    (i_entry_blue),
        .i_entry_green   (i_entry_green),
        .i_entry_red     (i_entry_red),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_pixel_blue    (o_pixel_blue),
        .o_pixel_green   (o_pixel_green),
        .o_pixel_red     (o_pixel_red),
        .o_last_of_byte  (o_last_of_byte),
        .o_row_end       (o_row_end)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < pebgr_pkg::TABLE_DEPTH; i++) color_tab[i] = '0;
    end

    function automatic int row_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_W) return MAX_W;
        return cfg_width;
    endfunction

    function automatic int row_bpp();
        case (cfg_depth)
            pebgr_pkg::DEPTH_1BPP: return 1;
            pebgr_pkg::DEPTH_4BPP: return 4;
            default:               return 8;
        endcase
    endfunction

    function automatic int row_stride();
        return ((row_width() * row_bpp() + 31) / 32) * 4;
    endfunction

    // Expand one accepted word into the pixels it should produce.
    function automatic void expand_word(input t_word w);
        int         wd;
        int         bpp;
        int         n;
        int         k;
        logic [7:0] ix;
        t_pixel     px;
        if (w.mode == pebgr_pkg::MODE_PALETTE) begin
            color_tab[w.pidx] = {w.blue, w.green, w.red};
        end else begin
            wd  = row_width();
            bpp = row_bpp();
            n   = (row_col < wd) ? wd - row_col : 0;
            if (n > 8 / bpp) n = 8 / bpp;
            for (k = 0; k < n; k++) begin
                if (bpp == 1) ix = {7'd0, w.data[7 - k]};
                else if (bpp == 4) ix = (k == 0) ? {4'd0, w.data[7:4]} : {4'd0, w.data[3:0]};
                else ix = w.data;
                px.blue  = color_tab[ix][23:16];
                px.green = color_tab[ix][15:8];
                px.red   = color_tab[ix][7:0];
                px.last  = (k + 1 == n);
                px.rend  = (row_col + 1 == wd);
                pixel_expect.push_back(px);
                row_col++;
            end
            // the byte that completes the stride starts a new row
            if (row_pos + 1 >= row_stride()) begin
                row_pos = 0;
                row_col = 0;
            end else begin
                row_pos++;
            end
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_sender || r < 65) return 0;
        if (r < 96) return $urandom_range(1, 4);
        return $urandom_range(15, 50);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_loaded = 1'b0;
            gap_left    = 0;
            i_valid <= 1'b0;
        end else begin
            if (word_loaded && !o_stall) begin
                expand_word(cur_word);
                word_loaded = 1'b0;
                gap_left    = pick_gap();
            end
            if (!word_loaded) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_words.size() != 0) begin
                    cur_word    = pending_words.pop_front();
                    word_loaded = 1'b1;
                    i_mode          <= cur_word.mode;
                    i_palette_index <= cur_word.pidx;
                    i_entry_blue    <= cur_word.blue;
                    i_entry_green   <= cur_word.green;
                    i_entry_red     <= cur_word.red;
                    i_data_byte     <= cur_word.data;
                end
            end
            i_valid <= word_loaded;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left = 0;
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (pixel_expect.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected pixel: b=%h g=%h r=%h last=%b end=%b",
                                 o_pixel_blue, o_pixel_green, o_pixel_red,
                                 o_last_of_byte, o_row_end);
                end else begin
                    want = pixel_expect.pop_front();
                    if (o_pixel_blue !== want.blue || o_pixel_green !== want.green ||
                        o_pixel_red !== want.red || o_last_of_byte !== want.last ||
                        o_row_end !== want.rend) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"pixel mismatch: exp b=%h g=%h r=%h last=%b end=%b,",
                                      " got b=%h g=%h r=%h last=%b end=%b"},
                                     want.blue, want.green, want.red, want.last, want.rend,
                                     o_pixel_blue, o_pixel_green, o_pixel_red,
                                     o_last_of_byte, o_row_end);
                    end
                end
            end
            stall_now = 1'b0;
            if (stall_left > 0) begin
                stall_left--;
                stall_now = 1'b1;
            end else if (!calm_receiver && $urandom_range(0, 99) < 30) begin
                stall_left = ($urandom_range(0, 24) == 0) ? $urandom_range(15, 50)
                                                          : $urandom_range(0, 3);
                stall_now = 1'b1;
            end
            i_stall <= stall_now;
        end
    end

    task automatic write_reg(input logic idx, input logic [pebgr_pkg::CFG_DW-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == pebgr_pkg::REG_PIXEL_DEPTH) cfg_depth = val[1:0];
        else cfg_width = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_format(input logic [1:0] depth,
                              input logic [pebgr_pkg::CFG_DW-1:0] width);
        write_reg(pebgr_pkg::REG_PIXEL_DEPTH, {11'd0, depth});
        write_reg(pebgr_pkg::REG_IMAGE_WIDTH, width);
        @(negedge i_clk);
    endtask

    task automatic push_palette(input logic [7:0] idx, input logic [7:0] b,
                                input logic [7:0] g, input logic [7:0] r);
        t_word w;
        w = '{mode: pebgr_pkg::MODE_PALETTE, pidx: idx, blue: b, green: g, red: r,
              data: 8'($urandom)};
        pending_words.push_back(w);
    endtask

    task automatic push_byte(input logic [7:0] d);
        t_word w;
        w = '{mode: pebgr_pkg::MODE_DATA, pidx: 8'($urandom), blue: 8'($urandom),
              green: 8'($urandom), red: 8'($urandom), data: d};
        pending_words.push_back(w);
    endtask

    // hold until every word is taken and every pixel has come out
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || i_valid || pixel_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_rand_bytes(input int count);
        int r;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 6) == 0) begin
                push_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
                random_items++;
            end
            r = $urandom_range(0, 9);
            push_byte(r == 0 ? 8'h00 : r == 1 ? 8'hFF : 8'($urandom));
            random_items++;
        end
    endtask

    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        logic [1:0]                   depth_pick;
        logic [pebgr_pkg::CFG_DW-1:0] width_pick;
        int                           r;
        int                           rows;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset format: 8 bpp, one pixel, three padding bytes per row
        push_byte(8'h00);                       // table still all zero
        push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
        push_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
        push_palette(8'hFF, 8'h12, 8'h34, 8'h56);
        push_palette(8'h01, 8'h80, 8'h01, 8'h7F);
        push_palette(8'h0F, 8'hA5, 8'h5A, 8'hC3);
        push_byte(8'hFF);
        push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        wait_drained();

        // 1 bpp, MSB first, second byte only partly used
        set_format(pebgr_pkg::DEPTH_1BPP, 13'd9);
        push_byte(8'hA5); push_byte(8'h80); push_byte(8'h7F); push_byte(8'h01);
        wait_drained();

        // 4 bpp, odd width: second byte uses the high nibble only
        set_format(pebgr_pkg::DEPTH_4BPP, 13'd3);
        push_byte(8'h1F); push_byte(8'hF0); push_byte(8'h11); push_byte(8'h22);
        wait_drained();

        // undefined depth and zero width
        set_format(DEPTH_UNDEF, 13'd0);
        push_byte(8'h01); push_byte(8'h0F); push_byte(8'hFF); push_byte(8'h00);
        wait_drained();

        // oversize width, leave the row open
        set_format(pebgr_pkg::DEPTH_8BPP, 13'h1FFF);
        push_byte(8'hFF); push_byte(8'h00); push_byte(8'h01);
        wait_drained();

        // shrink mid-row: the next byte closes the row with no pixels
        set_format(pebgr_pkg::DEPTH_1BPP, 13'd2);
        push_byte(8'hFF);
        push_byte(8'hC0); push_byte(8'h00); push_byte(8'h00); push_byte(8'h00);
        wait_drained();

        while (random_items < 60) begin
            r = $urandom_range(0, 9);
            depth_pick = (r < 3) ? pebgr_pkg::DEPTH_1BPP :
                         (r < 6) ? pebgr_pkg::DEPTH_4BPP :
                         (r < 9) ? pebgr_pkg::DEPTH_8BPP : DEPTH_UNDEF;
            r = $urandom_range(0, 19);
            if (r == 0) width_pick = 13'(MAX_W);
            else if (r == 1) width_pick = 13'd0;
            else if (r == 2) width_pick = 13'($urandom_range(MAX_W + 1, 8191));
            else width_pick = 13'($urandom_range(1, 40));
            calm_sender   = ($urandom_range(0, 3) == 0);
            calm_receiver = ($urandom_range(0, 3) == 0);
            set_format(depth_pick, width_pick);
            if (row_width() > 64) begin
                // long rows: a few bytes only, the next format change cuts in
                push_rand_bytes($urandom_range(2, 6));
            end else begin
                rows = $urandom_range(1, 3);
                for (int i = 0; i < rows; i++) begin
                    if ($urandom_range(0, 5) == 0)
                        push_rand_bytes($urandom_range(1, row_stride()));
                    else
                        push_rand_bytes(row_stride());
                end
            end
            wait_drained();
        end

        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0 && pixel_expect.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/pebgr_pkg.sv
hdl/pebgr_ram.sv
hdl/palette_expand_to_bgr24.sv
test/tb_top.sv
